// ===== src/rcmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rcmt_pkg - shared definitions for the RGBA color matrix transform
// Widths, fixed-point format and configuration register indexes.
// ----------------------------------------------------------------------------
package rcmt_pkg;

    localparam int FRACTION_BITS = 8;

    localparam int NUM_CH  = 4;
    localparam int PIX_W   = 8;
    localparam int WGT_W   = 16;
    localparam int OFS_W   = 24;
    localparam int ROW_W   = NUM_CH * WGT_W;
    localparam int OFS2_W  = 2 * OFS_W;
    localparam int CFG_W   = ROW_W;
    localparam int IDX_W   = 3;

    // unsigned pixel (as signed PIX_W+1) times signed weight
    localparam int PROD_W  = PIX_W + 1 + WGT_W;
    // pair of products, or pair of products plus offset
    localparam int PSUM_W  = PROD_W + 1;
    // full channel sum
    localparam int SUM_W   = PSUM_W + 1;

    localparam logic [ROW_W-1:0] RED_ROW_RST   = ROW_W'(64'd256);
    localparam logic [ROW_W-1:0] GREEN_ROW_RST = ROW_W'(64'd256 << 16);
    localparam logic [ROW_W-1:0] BLUE_ROW_RST  = ROW_W'(64'd256 << 32);
    localparam logic [ROW_W-1:0] ALPHA_ROW_RST = ROW_W'(64'd256 << 48);

    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_RED_ROW   = 3'd0,
        REG_GREEN_ROW = 3'd1,
        REG_BLUE_ROW  = 3'd2,
        REG_ALPHA_ROW = 3'd3,
        REG_RG_OFS    = 3'd4,
        REG_BA_OFS    = 3'd5,
        REG_SAT_MODE  = 3'd6
    } t_reg_idx;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PSUM_W-1:0] t_psum;
    typedef logic signed [SUM_W-1:0]  t_sum;

endpackage

// ===== src/rgba_color_matrix_transform.sv =====
// ----------------------------------------------------------------------------
// rgba_color_matrix_transform - 4x4 color matrix with offset column
// Per-pixel weighted sum of RGBA channels plus offset, scaled, then wrapped
// or clamped to 8 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* carries one RGBA pixel per transaction, tlast marks
//   the final pixel of an image. Master stream m_axis_* returns one
//   transformed pixel per input pixel, in order; tlast is passed through and
//   tuser flags a clamped channel (clamp mode only).
//   Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data): indexes
//   0..3 are the weight rows for red, green, blue and alpha outputs, 4 and 5
//   the offset pairs, 6 the clamp mode. Write only while the pipeline is empty.
//   Pipeline: four register stages (multiply, add tree, add, scale); throughput
//   is one pixel per cycle while the receiver keeps m_axis_tready high.
//   Each stage holds while the next one is full and stalled; empty stages
//   keep accepting, so a stalled receiver backs the pipeline up stage by stage
//   and s_axis_tready drops only when all four stages are full.
//   Reset empties the pipeline and restores an identity matrix, zero offsets
//   and wrap mode.
// ----------------------------------------------------------------------------
module rgba_color_matrix_transform (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
    input  logic                          s_axis_tlast,

    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic                          m_axis_tuser,  // any_clamped
    output logic                          m_axis_tlast,

    input  logic                          i_cfg_we,
    input  logic [rcmt_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [rcmt_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int NCH = rcmt_pkg::NUM_CH;
    localparam int PW  = rcmt_pkg::PIX_W;
    localparam int WW  = rcmt_pkg::WGT_W;
    localparam int OW  = rcmt_pkg::OFS_W;
    localparam int FB  = rcmt_pkg::FRACTION_BITS;
    localparam int SW  = rcmt_pkg::SUM_W;
    localparam int NST = 4;

    // configuration
    logic [rcmt_pkg::ROW_W-1:0]  r_row [NCH];
    logic [rcmt_pkg::OFS2_W-1:0] r_ofs_rg;
    logic [rcmt_pkg::OFS2_W-1:0] r_ofs_ba;
    logic                        r_sat_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= rcmt_pkg::RED_ROW_RST;
            r_row[1]   <= rcmt_pkg::GREEN_ROW_RST;
            r_row[2]   <= rcmt_pkg::BLUE_ROW_RST;
            r_row[3]   <= rcmt_pkg::ALPHA_ROW_RST;
            r_ofs_rg   <= '0;
            r_ofs_ba   <= '0;
            r_sat_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (rcmt_pkg::t_reg_idx'(i_cfg_idx))
                rcmt_pkg::REG_RED_ROW:   r_row[0]   <= i_cfg_data;
                rcmt_pkg::REG_GREEN_ROW: r_row[1]   <= i_cfg_data;
                rcmt_pkg::REG_BLUE_ROW:  r_row[2]   <= i_cfg_data;
                rcmt_pkg::REG_ALPHA_ROW: r_row[3]   <= i_cfg_data;
                rcmt_pkg::REG_RG_OFS:    r_ofs_rg   <= i_cfg_data[rcmt_pkg::OFS2_W-1:0];
                rcmt_pkg::REG_BA_OFS:    r_ofs_ba   <= i_cfg_data[rcmt_pkg::OFS2_W-1:0];
                rcmt_pkg::REG_SAT_MODE:  r_sat_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [OW-1:0] w_ofs [NCH];
    assign w_ofs[0] = $signed(r_ofs_rg[OW-1:0]);
    assign w_ofs[1] = $signed(r_ofs_rg[2*OW-1:OW]);
    assign w_ofs[2] = $signed(r_ofs_ba[OW-1:0]);
    assign w_ofs[3] = $signed(r_ofs_ba[2*OW-1:OW]);

    // stage handshake
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_rdy;

    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: products
    rcmt_pkg::t_prod r_prod [NCH][NCH];
    logic            r_last0;
    logic            r_last1;
    logic            r_last2;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_last0 <= s_axis_tlast;
            for (int c = 0; c < NCH; c++) begin
                for (int k = 0; k < NCH; k++) begin
                    r_prod[c][k] <= $signed({1'b0, s_axis_tdata[k*PW +: PW]})
                                  * $signed(r_row[c][k*WW +: WW]);
                end
            end
        end
    end

    // stage 1: pairwise sums, offset folded in
    rcmt_pkg::t_psum r_psum_a [NCH];
    rcmt_pkg::t_psum r_psum_b [NCH];

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_last1 <= r_last0;
            for (int c = 0; c < NCH; c++) begin
                r_psum_a[c] <= rcmt_pkg::PSUM_W'(r_prod[c][0])
                             + rcmt_pkg::PSUM_W'(r_prod[c][1]);
                r_psum_b[c] <= rcmt_pkg::PSUM_W'(r_prod[c][2])
                             + rcmt_pkg::PSUM_W'(r_prod[c][3])
                             + rcmt_pkg::PSUM_W'(w_ofs[c]);
            end
        end
    end

    // stage 2: channel sums
    rcmt_pkg::t_sum r_sum [NCH];

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_last2 <= r_last1;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= SW'(r_psum_a[c]) + SW'(r_psum_b[c]);
            end
        end
    end

    // stage 3: scale, then wrap or clamp
    logic [PW-1:0] n_chan [NCH];
    logic          n_clamp;

    always_comb begin
        logic neg;
        logic frac_nz;
        logic over;
        n_clamp = 1'b0;
        for (int c = 0; c < NCH; c++) begin
            neg     = r_sum[c][SW-1];
            frac_nz = |r_sum[c][FB-1:0];
            over    = |r_sum[c][SW-2:FB+PW];
            if (!r_sat_mode) begin
                n_chan[c] = r_sum[c][FB +: PW] + PW'(neg && frac_nz);
            end else if (neg) begin
                n_chan[c] = '0;
                n_clamp   = 1'b1;
            end else if (over) begin
                n_chan[c] = rcmt_pkg::PIX_MAX;
                n_clamp   = 1'b1;
            end else begin
                n_chan[c] = r_sum[c][FB +: PW];
            end
        end
    end

    logic [PW-1:0] r_chan [NCH];
    logic          r_clamp;
    logic          r_last_out;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_last_out <= r_last2;
            r_clamp    <= n_clamp;
            for (int c = 0; c < NCH; c++) begin
                r_chan[c] <= n_chan[c];
            end
        end
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = {r_chan[3], r_chan[2], r_chan[1], r_chan[0]};
    assign m_axis_tuser  = r_clamp;
    assign m_axis_tlast  = r_last_out;

`ifndef SYNTHESIS
    a_clamp_only_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> r_sat_mode)
        else $error("clamp flag set in wrap mode");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (r_chan[0] == '0) || (r_chan[0] == rcmt_pkg::PIX_MAX) ||
            (r_chan[1] == '0) || (r_chan[1] == rcmt_pkg::PIX_MAX) ||
            (r_chan[2] == '0) || (r_chan[2] == rcmt_pkg::PIX_MAX) ||
            (r_chan[3] == '0) || (r_chan[3] == rcmt_pkg::PIX_MAX))
        else $error("clamp flag without a clamped channel");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld) && !m_axis_tready)
        else $error("input stalled while pipeline has room");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted pixel did not enter first stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== sim/rgba_color_matrix_transform_tb.sv =====
// ----------------------------------------------------------------------------
// rgba_color_matrix_transform_tb - self-checking testbench
// Streams RGBA pixels through the color matrix under several weight, offset
// and mode settings. Each pixel's expected output, computed in the bench at
// acceptance time or given in the directed table, is compared field by field
// with the returned pixel. A short directed table covers identity, extremes and
// the clamp corners; random phases with stalls on both sides make up the rest.
// ----------------------------------------------------------------------------
module rgba_color_matrix_transform_tb;

    localparam int  PIX_W         = rcmt_pkg::PIX_W;
    localparam int  WGT_W         = rcmt_pkg::WGT_W;
    localparam int  OFS_W         = rcmt_pkg::OFS_W;
    localparam int  ROW_W         = rcmt_pkg::ROW_W;
    localparam int  OFS2_W        = rcmt_pkg::OFS2_W;
    localparam int  CFG_W         = rcmt_pkg::CFG_W;
    localparam int  IDX_W         = rcmt_pkg::IDX_W;
    localparam int  NUM_CH        = rcmt_pkg::NUM_CH;
    localparam int  FRACTION_BITS = rcmt_pkg::FRACTION_BITS;

    localparam int  CLK_HALF     = 5;
    localparam int  RST_CYCLES   = 6;
    localparam int  SETTLE       = 12;
    localparam int  LONG_HOLD    = 80;
    localparam int  NUM_PHASES   = 6;
    localparam int  PHASE_ITEMS  = 106;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgba;

    typedef struct packed {
        t_rgba pix;
        logic  clamped;
        logic  last;
    } t_pixel_out;

    typedef enum logic {ROW_CFG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        t_rgba            pix;
        logic             last;
        bit               typed;
        t_pixel_out       want;
    } t_stim_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;   // red_in, green_in, blue_in, alpha_in
    logic             s_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [31:0]      m_axis_tdata;   // red_out, green_out, blue_out, alpha_out
    logic             m_axis_tuser;   // any_clamped
    logic             m_axis_tlast;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    logic [ROW_W-1:0]  row_weights [NUM_CH];
    logic [OFS2_W-1:0] offset_pairs [2];
    logic              clamp_mode;

    t_pixel_out  pending_pixels [$];
    t_stim_row   directed_rows [$];
    int          mismatch_count;
    int          cycle_count;
    bit          tx_idle_en;
    bit          rx_idle_en;
    bit          hold_req;
    int          hold_left;
    int          rx_gap;

    rgba_color_matrix_transform u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_pixel_out transform_pixel(t_rgba px, logic last);
        t_pixel_out              res;
        logic signed [WGT_W-1:0] wt;
        logic signed [OFS_W-1:0] ofs;
        longint                  acc;
        longint                  chan;
        longint                  quo;
        res = '0;
        res.last = last;
        for (int c = 0; c < NUM_CH; c++) begin
            ofs = offset_pairs[c / 2][(c % 2) * OFS_W +: OFS_W];
            acc = ofs;
            for (int k = 0; k < NUM_CH; k++) begin
                wt   = row_weights[c][k * WGT_W +: WGT_W];
                chan = px[k * PIX_W +: PIX_W];
                acc  = acc + chan * longint'(wt);
            end
            if (!clamp_mode) begin
                quo = acc / (longint'(1) << FRACTION_BITS);
            end else if (acc < 0) begin
                quo = 0;
                res.clamped = 1'b1;
            end else if (acc >= (longint'(256) << FRACTION_BITS)) begin
                quo = 255;
                res.clamped = 1'b1;
            end else begin
                quo = acc >>> FRACTION_BITS;
            end
            res.pix[c * PIX_W +: PIX_W] = quo[PIX_W-1:0];
        end
        return res;
    endfunction

    function automatic t_stim_row cfg_row(logic [IDX_W-1:0] idx,
                                          logic [CFG_W-1:0] data);
        t_stim_row r;
        r = '{kind: ROW_CFG, idx: idx, data: data, pix: '0, last: 1'b0, typed: 1'b0,
              want: '0};
        return r;
    endfunction

    function automatic t_stim_row pix_row(logic [31:0] px, logic last);
        t_stim_row r;
        r = '{kind: ROW_PIX, idx: '0, data: '0, pix: t_rgba'(px), last: last, typed: 1'b0,
              want: '0};
        return r;
    endfunction

    function automatic t_stim_row known_row(logic [31:0] px, logic last, logic [31:0] want_px,
                                            logic want_clamp);
        t_stim_row r;
        r = pix_row(px, last);
        r.typed = 1'b1;
        r.want  = '{pix: t_rgba'(want_px), clamped: want_clamp, last: last};
        return r;
    endfunction

    function automatic logic [WGT_W-1:0] pick_weight();
        logic [WGT_W-1:0] w;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: w = 16'h7FFF;
                    1: w = 16'h8000;
                    2: w = 16'h0000;
                    3: w = 16'h0100;
                    default: w = 16'hFFFF;
                endcase
            end
            3: w = WGT_W'($urandom);
            default: begin
                w = WGT_W'($urandom_range(0, 1023));
                w = w - 16'd512;
            end
        endcase
        return w;
    endfunction

    function automatic logic [OFS_W-1:0] pick_offset();
        logic [OFS_W-1:0] o;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: o = 24'h7FFFFF;
                    1: o = 24'h800000;
                    2: o = 24'h000000;
                    3: o = 24'hFFFFFF;
                    default: o = 24'h000080;
                endcase
            end
            3: o = OFS_W'($urandom);
            default: begin
                o = OFS_W'($urandom_range(0, 131071));
                o = o - 24'd65536;
            end
        endcase
        return o;
    endfunction

    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return rcmt_pkg::PIX_MAX;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            rcmt_pkg::REG_RED_ROW:   row_weights[0] = data;
            rcmt_pkg::REG_GREEN_ROW: row_weights[1] = data;
            rcmt_pkg::REG_BLUE_ROW:  row_weights[2] = data;
            rcmt_pkg::REG_ALPHA_ROW: row_weights[3] = data;
            rcmt_pkg::REG_RG_OFS:    offset_pairs[0] = data[OFS2_W-1:0];
            rcmt_pkg::REG_BA_OFS:    offset_pairs[1] = data[OFS2_W-1:0];
            rcmt_pkg::REG_SAT_MODE:  clamp_mode = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= {$urandom, $urandom};
    endtask

    // hold the input side until every pixel has come back and the pipeline settles
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_pixel(t_rgba px, logic last, bit typed, t_pixel_out want);
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_pixels.push_back(typed ? want : transform_pixel(px, last));
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(1, 19) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected transaction", m_axis_tdata, '0);
            end else begin
                want = pending_pixels.pop_front();
                for (int c = 0; c < NUM_CH; c++) begin
                    if (m_axis_tdata[c * PIX_W +: PIX_W] !== want.pix[c * PIX_W +: PIX_W])
                        report_mismatch($sformatf("channel %0d", c),
                                        32'(m_axis_tdata[c * PIX_W +: PIX_W]),
                                        32'(want.pix[c * PIX_W +: PIX_W]));
                end
                if (m_axis_tuser !== want.clamped)
                    report_mismatch("clamp flag", 32'(m_axis_tuser), 32'(want.clamped));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last flag", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_stim_row        row;
        t_row_kind        prev_kind;
        logic [CFG_W-1:0] data;
        t_rgba            px;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        mismatch_count = 0;
        hold_req       = 1'b0;
        hold_left      = 0;
        rx_gap         = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        row_weights[0] = rcmt_pkg::RED_ROW_RST;
        row_weights[1] = rcmt_pkg::GREEN_ROW_RST;
        row_weights[2] = rcmt_pkg::BLUE_ROW_RST;
        row_weights[3] = rcmt_pkg::ALPHA_ROW_RST;
        offset_pairs[0] = '0;
        offset_pairs[1] = '0;
        clamp_mode      = 1'b0;

        // identity matrix after reset: pixels come back unchanged
        directed_rows.push_back(known_row(32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0));
        directed_rows.push_back(known_row(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(known_row(32'h7F80_01FE, 1'b0, 32'h7F80_01FE, 1'b0));
        directed_rows.push_back(known_row(32'h0102_0408, 1'b1, 32'h0102_0408, 1'b0));
        // extreme weights and offsets, negative offset truncates toward zero
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_RED_ROW,   64'h7FFF_7FFF_7FFF_7FFF));
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_GREEN_ROW, 64'h8000_8000_8000_8000));
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_BLUE_ROW,  64'h0000_0000_0000_0000));
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_ALPHA_ROW, 64'hFF00_0080_FFFF_0100));
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_RG_OFS,    64'hABCD_8000_007F_FFFF));
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_BA_OFS,    64'h5A5A_0000_80FF_FFFF));
        directed_rows.push_back(cfg_row(REG_UNUSED,              64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(pix_row(32'hFFFF_FFFF, 1'b0));
        directed_rows.push_back(pix_row(32'h0000_0000, 1'b1));
        directed_rows.push_back(pix_row(32'h0101_0101, 1'b0));
        directed_rows.push_back(pix_row(32'hFF00_FF00, 1'b0));
        // clamp mode: large, negative and small negative sums
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_SAT_MODE,  64'h8000_0000_0000_0001));
        directed_rows.push_back(pix_row(32'h0000_0000, 1'b0));
        directed_rows.push_back(pix_row(32'hFFFF_FFFF, 1'b1));
        directed_rows.push_back(pix_row(32'h1020_3040, 1'b0));
        // clamp boundary: red sum of exactly 256.0 clamps, one step lower does not
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_RED_ROW,   64'h0000_0000_0000_0100));
        directed_rows.push_back(cfg_row(rcmt_pkg::REG_RG_OFS,    64'h0000_0000_0000_0100));
        directed_rows.push_back(pix_row(32'h0000_00FF, 1'b0));
        directed_rows.push_back(pix_row(32'h0000_00FE, 1'b1));
        directed_rows.push_back(pix_row(32'h0000_0000, 1'b0));

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        prev_kind = ROW_CFG;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                if (prev_kind == ROW_PIX) wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                send_pixel(row.pix, row.last, row.typed, row.want);
            end
            prev_kind = row.kind;
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            if (p == NUM_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            for (int r = 0; r < NUM_CH; r++) begin
                data = {pick_weight(), pick_weight(), pick_weight(), pick_weight()};
                write_reg(IDX_W'(rcmt_pkg::REG_RED_ROW + r), data);
            end
            write_reg(rcmt_pkg::REG_RG_OFS, {16'($urandom), pick_offset(), pick_offset()});
            write_reg(rcmt_pkg::REG_BA_OFS, {16'($urandom), pick_offset(), pick_offset()});
            data = {$urandom, $urandom};
            data[0] = (p % 2 == 1);
            write_reg(rcmt_pkg::REG_SAT_MODE, data);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 20) hold_req = 1'b1;
                if (p == 2 && n == PHASE_ITEMS / 2) wait_idle();
                px = {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
                send_pixel(px, ($urandom_range(0, 15) == 0), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
